>>> hw/rtl/ycd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycd_pkg
// shared types, widths and colour-space constants of the yiq colour delta
// ----------------------------------------------------------------------------
package ycd_pkg;

	localparam int COEF_FRAC_BITS_DEF = 16;

	localparam int CH_W    = 8;
	localparam int PROD_W  = 16;
	localparam int BLEND_W = 16;
	localparam int DCH_W   = 17;
	localparam int D_W     = 18;
	localparam int SQ_W    = 34;
	localparam int SQ_LO_W = 17;
	localparam int DIFF_W  = 26;

	// reciprocal of 255: floor(y * RECIP_K / 2^RECIP_SHIFT) == floor(y / 255) for y < 2^24
	localparam int                  RECIP_W     = 25;
	localparam int                  RECIP_SHIFT = 32;
	localparam logic [RECIP_W-1:0]  RECIP_K     = 25'd16843010;
	localparam int                  DIV_IN_W    = 24;
	localparam logic [DIV_IN_W-1:0] DIV_BIAS    = 24'd127;

	localparam logic [DIFF_W-1:0] DIFF_MAX = {1'b0, {(DIFF_W - 1){1'b1}}};

	typedef logic        [CH_W-1:0]    chan_t;
	typedef logic        [BLEND_W-1:0] blend_t;
	typedef logic signed [DCH_W-1:0]   dch_t;
	typedef logic signed [D_W-1:0]     d_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;

	// stage advance strobes
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} chan_adv_t;

	typedef struct packed {
		logic s4;
		logic s5;
		logic s6;
		logic s7;
		logic s8;
	} comp_adv_t;

	// yiq rows, then distance weights, in units of 1e-8
	localparam longint COEF_DEN = 100_000_000;
	localparam longint COEF_E8 [12] = '{
		29889531, 58662247, 11448223,
		59597799, 27417610, 32180189,
		21147017, 52261711, 31114694,
		50530000, 29900000, 19570000
	};
	// subtracted terms: i row green and blue, q row green
	localparam logic [11:0] COEF_NEG = 12'h0B0;

	function automatic longint coef_mag(int idx, int frac);
		return ((COEF_E8[idx] << frac) + COEF_DEN / 2) / COEF_DEN;
	endfunction

	function automatic longint coef_signed(int idx, int frac);
		longint m;
		m = coef_mag(idx, frac);
		return COEF_NEG[idx] ? -m : m;
	endfunction

endpackage

>>> hw/rtl/ycd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycd interfaces
// pixel pair request, result request and configuration write channels
// ----------------------------------------------------------------------------
interface ycd_pair_if;
	logic          valid;
	logic          ready;
	ycd_pkg::chan_t first_red;
	ycd_pkg::chan_t first_green;
	ycd_pkg::chan_t first_blue;
	ycd_pkg::chan_t first_alpha;
	ycd_pkg::chan_t second_red;
	ycd_pkg::chan_t second_green;
	ycd_pkg::chan_t second_blue;
	ycd_pkg::chan_t second_alpha;

	modport source (
		output valid, first_red, first_green, first_blue, first_alpha,
		output second_red, second_green, second_blue, second_alpha,
		input  ready
	);
	modport sink (
		input  valid, first_red, first_green, first_blue, first_alpha,
		input  second_red, second_green, second_blue, second_alpha,
		output ready
	);
endinterface

interface ycd_result_if;
	logic           valid;
	logic           ready;
	ycd_pkg::diff_t difference;
	logic           pixels_equal;

	modport source (output valid, difference, pixels_equal, input ready);
	modport sink   (input valid, difference, pixels_equal, output ready);
endinterface

interface ycd_cfg_if;
	logic valid;
	logic ready;
	logic luma_only;

	modport source (output valid, luma_only, input ready);
	modport sink   (input valid, luma_only, output ready);
endinterface

>>> hw/rtl/ycd_chan_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycd_chan_lane
// one colour channel: blend both pixels over white, then take the difference
// ----------------------------------------------------------------------------
module ycd_chan_lane (
	input  logic                 clk,
	input  ycd_pkg::chan_adv_t   adv,
	input  ycd_pkg::chan_t       first_chan,
	input  ycd_pkg::chan_t       first_alpha,
	input  ycd_pkg::chan_t       second_chan,
	input  ycd_pkg::chan_t       second_alpha,
	output ycd_pkg::dch_t        dch_s3
);

	localparam int MUL_W = ycd_pkg::DIV_IN_W + ycd_pkg::RECIP_W;

	logic [ycd_pkg::PROD_W-1:0] p1_s1, p2_s1;
	ycd_pkg::chan_t             a1_s1, a2_s1;
	ycd_pkg::blend_t            b1_s2, b2_s2;
	logic [ycd_pkg::DIV_IN_W-1:0] y1_c, y2_c;
	logic [MUL_W-1:0]           m1_c, m2_c;
	ycd_pkg::blend_t            b1_c, b2_c;

	// stage 1: channel times alpha
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			p1_s1 <= ycd_pkg::PROD_W'(first_chan) * ycd_pkg::PROD_W'(first_alpha);
			p2_s1 <= ycd_pkg::PROD_W'(second_chan) * ycd_pkg::PROD_W'(second_alpha);
			a1_s1 <= first_alpha;
			a2_s1 <= second_alpha;
		end
	end

	// stage 2: (255-a)*256 is exact, only c*a*256/255 needs the reciprocal
	always_comb begin
		y1_c = {p1_s1, 8'd0} + ycd_pkg::DIV_BIAS;
		y2_c = {p2_s1, 8'd0} + ycd_pkg::DIV_BIAS;
		m1_c = MUL_W'(y1_c) * MUL_W'(ycd_pkg::RECIP_K);
		m2_c = MUL_W'(y2_c) * MUL_W'(ycd_pkg::RECIP_K);
		b1_c = {~a1_s1, 8'd0} + m1_c[ycd_pkg::RECIP_SHIFT +: ycd_pkg::BLEND_W];
		b2_c = {~a2_s1, 8'd0} + m2_c[ycd_pkg::RECIP_SHIFT +: ycd_pkg::BLEND_W];
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			b1_s2 <= b1_c;
			b2_s2 <= b2_c;
		end
	end

	// stage 3: signed difference
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			dch_s3 <= $signed({1'b0, b1_s2}) - $signed({1'b0, b2_s2});
		end
	end

endmodule

>>> hw/rtl/ycd_comp_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycd_comp_lane
// one yiq component: matrix row, rounding, square and distance weight
// ----------------------------------------------------------------------------
module ycd_comp_lane #(
	parameter int ROW            = 0,
	parameter int COEF_FRAC_BITS = ycd_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  ycd_pkg::comp_adv_t adv,
	input  ycd_pkg::dch_t      dch [3],
	output ycd_pkg::d_t        d_s5,
	output logic [COEF_FRAC_BITS+ycd_pkg::SQ_W-1:0] weighted_s8
);

	localparam int CW   = COEF_FRAC_BITS + 1;
	localparam int PW   = CW + ycd_pkg::DCH_W;
	localparam int SW   = PW + 2;
	localparam int WW   = COEF_FRAC_BITS;
	localparam int WPW  = WW + ycd_pkg::SQ_LO_W;
	localparam int HI_W = ycd_pkg::SQ_W - ycd_pkg::SQ_LO_W;
	localparam int OW   = WW + ycd_pkg::SQ_W;

	localparam logic signed [CW-1:0] COEF [3] = '{
		CW'(ycd_pkg::coef_signed(ROW * 3 + 0, COEF_FRAC_BITS)),
		CW'(ycd_pkg::coef_signed(ROW * 3 + 1, COEF_FRAC_BITS)),
		CW'(ycd_pkg::coef_signed(ROW * 3 + 2, COEF_FRAC_BITS))
	};
	localparam logic [WW-1:0] WEIGHT =
		WW'(ycd_pkg::coef_mag(9 + ROW, COEF_FRAC_BITS));
	localparam logic signed [SW-1:0] HALF =
		SW'(longint'(1) << (COEF_FRAC_BITS - 1));

	logic signed [PW-1:0]            prod_s4 [3];
	logic signed [SW-1:0]            sum_c, rnd_c;
	logic signed [2*ycd_pkg::D_W-1:0] sq_c;
	logic [ycd_pkg::SQ_W-1:0]        sq_s6;
	logic [WPW-1:0]                  wlo_s7, whi_s7;

	// stage 4: three products of the row
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			for (int j = 0; j < 3; j++) begin
				prod_s4[j] <= PW'(COEF[j]) * PW'(dch[j]);
			end
		end
	end

	// stage 5: sum and round to q8, ties away from zero
	always_comb begin
		sum_c = SW'(prod_s4[0]) + SW'(prod_s4[1]) + SW'(prod_s4[2]);
		rnd_c = sum_c + HALF - $signed(SW'(sum_c[SW-1]));
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			d_s5 <= ycd_pkg::D_W'(rnd_c >>> COEF_FRAC_BITS);
		end
	end

	// stage 6: square
	assign sq_c = d_s5 * d_s5;

	always_ff @(posedge clk) begin
		if (adv.s6) begin
			sq_s6 <= sq_c[ycd_pkg::SQ_W-1:0];
		end
	end

	// stage 7: weight times square, split into two partial products
	always_ff @(posedge clk) begin
		if (adv.s7) begin
			wlo_s7 <= WPW'(WEIGHT) * WPW'(sq_s6[ycd_pkg::SQ_LO_W-1:0]);
			whi_s7 <= WPW'(WEIGHT) * WPW'(sq_s6[ycd_pkg::SQ_LO_W +: HI_W]);
		end
	end

	// stage 8: recombine
	always_ff @(posedge clk) begin
		if (adv.s8) begin
			weighted_s8 <= (OW'(whi_s7) << ycd_pkg::SQ_LO_W) + OW'(wlo_s7);
		end
	end

endmodule

>>> hw/rtl/yiq_color_delta.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yiq_color_delta
// perceptual colour difference of two rgba pixels in yiq space
// ----------------------------------------------------------------------------
// One pixel pair per clock goes in unless result back-pressure holds the pipeline,
// and one result per pair comes out. The request passes through ten register
// stages, s1 to s10, and the result channel is driven from the s10 registers.
// Three channel lanes (red, green, blue) blend each pixel over white and
// subtract; three component lanes (y, i, q) apply the matrix row, round to
// q8, square and weight; a merge stage adds the weighted squares, and the sum
// is rounded once on its way into the output stage. Every stage has its own
// valid bit and moves on whenever the stage after it is empty or moving, so a
// stalled result only holds back the stages behind it and bubbles close up.
// Identical pixels give difference 0 with pixels_equal set. With luma_only
// set the result is the signed y difference in q8, otherwise the weighted
// distance in q8, clipped at 2^25-1. luma_only is written through the cfg
// channel, which is always ready; write it only while no request is in flight.
// ----------------------------------------------------------------------------
module yiq_color_delta #(
	parameter int COEF_FRAC_BITS = ycd_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ycd_pair_if.sink      pixels,
	ycd_cfg_if.sink       cfg,
	ycd_result_if.source  result
);

	localparam int NSTAGE = 10;
	localparam int OW     = COEF_FRAC_BITS + ycd_pkg::SQ_W;
	localparam int TW     = OW + 2;
	localparam int RS     = COEF_FRAC_BITS + 8;
	localparam logic [TW:0] RHALF = (TW + 1)'(1) << (RS - 1);

	// stage valids and advance strobes
	logic [NSTAGE:1]    v_q;
	logic [NSTAGE:1]    adv;
	ycd_pkg::chan_adv_t chan_adv;
	ycd_pkg::comp_adv_t comp_adv;

	logic luma_only_q;

	ycd_pkg::chan_t first_ch [3];
	ycd_pkg::chan_t second_ch [3];
	ycd_pkg::dch_t  dch [3];
	ycd_pkg::d_t    d_lane [3];
	logic [OW-1:0]  weighted [3];

	logic eq_c;
	logic eq_s1, eq_s2, eq_s3, eq_s4, eq_s5, eq_s6, eq_s7, eq_s8, eq_s9;
	ycd_pkg::d_t    dy_s6, dy_s7, dy_s8, dy_s9;
	logic [TW-1:0]  w_sum_s9;
	logic [TW:0]    rnd_c;
	logic [TW:0]    dist_c;
	ycd_pkg::diff_t diff_c;
	ycd_pkg::diff_t difference_s10;
	logic           equal_s10;

	// configuration register, taken in any cycle
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_only_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			luma_only_q <= cfg.luma_only;
		end
	end

	// a stage moves when it is empty or the next one moves
	always_comb begin
		adv[NSTAGE] = !v_q[NSTAGE] || result.ready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			adv[k] = !v_q[k] || adv[k + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[1]) begin
				v_q[1] <= pixels.valid;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (adv[k]) begin
					v_q[k] <= v_q[k - 1];
				end
			end
		end
	end

	assign pixels.ready = adv[1];

	assign chan_adv = '{s1: adv[1], s2: adv[2], s3: adv[3]};
	assign comp_adv = '{s4: adv[4], s5: adv[5], s6: adv[6], s7: adv[7], s8: adv[8]};

	// colour channels in lane order red, green, blue
	assign first_ch[0]  = pixels.first_red;
	assign first_ch[1]  = pixels.first_green;
	assign first_ch[2]  = pixels.first_blue;
	assign second_ch[0] = pixels.second_red;
	assign second_ch[1] = pixels.second_green;
	assign second_ch[2] = pixels.second_blue;

	for (genvar g = 0; g < 3; g++) begin : g_chan
		ycd_chan_lane u_chan (
			.clk          (clk),
			.adv          (chan_adv),
			.first_chan   (first_ch[g]),
			.first_alpha  (pixels.first_alpha),
			.second_chan  (second_ch[g]),
			.second_alpha (pixels.second_alpha),
			.dch_s3       (dch[g])
		);
	end

	// component lanes y, i, q all see the three channel differences
	for (genvar g = 0; g < 3; g++) begin : g_comp
		ycd_comp_lane #(
			.ROW            (g),
			.COEF_FRAC_BITS (COEF_FRAC_BITS)
		) u_comp (
			.clk         (clk),
			.adv         (comp_adv),
			.dch         (dch),
			.d_s5        (d_lane[g]),
			.weighted_s8 (weighted[g])
		);
	end

	// identical pixels bypass the arithmetic at the output
	assign eq_c = (pixels.first_red   == pixels.second_red)   &&
	              (pixels.first_green == pixels.second_green) &&
	              (pixels.first_blue  == pixels.second_blue)  &&
	              (pixels.first_alpha == pixels.second_alpha);

	// side band: equal flag and luma difference travel with the request
	always_ff @(posedge clk) begin
		if (adv[1]) eq_s1 <= eq_c;
		if (adv[2]) eq_s2 <= eq_s1;
		if (adv[3]) eq_s3 <= eq_s2;
		if (adv[4]) eq_s4 <= eq_s3;
		if (adv[5]) eq_s5 <= eq_s4;
		if (adv[6]) begin
			eq_s6 <= eq_s5;
			dy_s6 <= d_lane[0];
		end
		if (adv[7]) begin
			eq_s7 <= eq_s6;
			dy_s7 <= dy_s6;
		end
		if (adv[8]) begin
			eq_s8 <= eq_s7;
			dy_s8 <= dy_s7;
		end
		if (adv[9]) begin
			eq_s9 <= eq_s8;
			dy_s9 <= dy_s8;
		end
	end

	// merge: add the three weighted squares
	always_ff @(posedge clk) begin
		if (adv[9]) begin
			w_sum_s9 <= TW'(weighted[0]) + TW'(weighted[1]) + TW'(weighted[2]);
		end
	end

	// round once to q8, clip, and pick the result for the mode
	always_comb begin
		rnd_c  = (TW + 1)'(w_sum_s9) + RHALF;
		dist_c = rnd_c >> RS;
		if (eq_s9) begin
			diff_c = '0;
		end else if (luma_only_q) begin
			diff_c = ycd_pkg::DIFF_W'(dy_s9);
		end else if (dist_c > (TW + 1)'(ycd_pkg::DIFF_MAX)) begin
			diff_c = ycd_pkg::DIFF_MAX;
		end else begin
			diff_c = ycd_pkg::DIFF_W'(dist_c);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NSTAGE]) begin
			difference_s10 <= diff_c;
			equal_s10      <= eq_s9;
		end
	end

	assign result.valid        = v_q[NSTAGE];
	assign result.difference   = difference_s10;
	assign result.pixels_equal = equal_s10;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the yiq colour delta block
// ----------------------------------------------------------------------------
// Pixel pair requests go in through the pixels channel and results are taken
// from the result channel under random back-pressure. Every accepted request
// is run through a bit-accurate predictor of the blend, yiq and weighting
// arithmetic, and the prediction is queued. Each result is then checked
// field by field against the oldest queued prediction. Both modes are
// covered, along with alpha blending and identical pixels, followed by a
// long random run.
// ----------------------------------------------------------------------------
module testbench;

	localparam int     CLK_HALF      = 5;
	localparam int     CYCLE_LIMIT   = 400000;
	localparam int     SETTLE_CYCLES = 16;   // pipeline is ten deep, plus margin
	localparam int     MAX_REPORTS   = 40;
	localparam int     COEF_FRAC     = ycd_pkg::COEF_FRAC_BITS_DEF;
	localparam int     Q8_SHIFT      = 8;
	localparam longint DISTANCE_CLIP = (longint'(1) << (ycd_pkg::DIFF_W - 1)) - 1;
	localparam longint UNIT_E8       = 100_000_000;

	// y row, i row, q row magnitudes, then the distance weights, in 1e-8
	localparam longint WEIGHT_E8 [12] = '{
		29889531, 58662247, 11448223,
		59597799, 27417610, 32180189,
		21147017, 52261711, 31114694,
		50530000, 29900000, 19570000
	};

	typedef enum bit {
		MODE_DISTANCE = 1'b0,
		MODE_LUMA     = 1'b1
	} mode_t;

	typedef struct packed {
		ycd_pkg::chan_t first_red;
		ycd_pkg::chan_t first_green;
		ycd_pkg::chan_t first_blue;
		ycd_pkg::chan_t first_alpha;
		ycd_pkg::chan_t second_red;
		ycd_pkg::chan_t second_green;
		ycd_pkg::chan_t second_blue;
		ycd_pkg::chan_t second_alpha;
	} pixel_pair_t;

	typedef struct {
		pixel_pair_t    pair;
		ycd_pkg::diff_t difference;
		logic           pixels_equal;
	} colour_delta_t;

	logic clk;
	logic arst_n;

	ycd_pair_if   pix_if ();
	ycd_cfg_if    cfg_if ();
	ycd_result_if res_if ();

	yiq_color_delta DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pix_if),
		.cfg    (cfg_if),
		.result (res_if)
	);

	// predicted deltas, oldest first, one per accepted request
	colour_delta_t pending_deltas [$];

	// shadow of the luma_only register as the block holds it
	mode_t luma_mode = MODE_DISTANCE;
	bit    idle_en   = 1'b0;
	int    sink_stall;

	int cycle_count;
	int mismatch_count;
	int pairs_sent;
	int equal_pairs;
	int results_checked;
	int mode_writes;

	// ------------------------------------------------------------------------
	// clock and watchdog
	// ------------------------------------------------------------------------
	initial clk = 1'b0;
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_deltas.size());
			$display("** yiq_color_delta: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------
	// coefficient rounded to the fixed-point grid, ties upward
	function automatic longint coef_q16(int idx);
		return ((WEIGHT_E8[idx] << COEF_FRAC) + UNIT_E8 / 2) / UNIT_E8;
	endfunction

	// divide by 2^s, nearest, ties away from zero
	function automatic longint round_q(longint x, int s);
		longint mag;
		mag = (x < 0) ? -x : x;
		mag = (mag + (longint'(1) << (s - 1))) >>> s;
		return (x < 0) ? -mag : mag;
	endfunction

	// channel laid over white, in q8
	function automatic longint blend_q8(ycd_pkg::chan_t c, ycd_pkg::chan_t a);
		longint cv;
		longint av;
		cv = longint'(c);
		av = longint'(a);
		if (av == 255)
			return cv << Q8_SHIFT;
		return ((cv * av + 255 * (255 - av)) * 256 + 127) / 255;
	endfunction

	function automatic colour_delta_t predict_colour_delta(pixel_pair_t p, mode_t m);
		colour_delta_t r;
		longint        dr;
		longint        dg;
		longint        db;
		longint        dy;
		longint        di;
		longint        dq;
		longint        sum;
		longint        distance;
		r.pair = p;
		r.pixels_equal = 1'b0;
		if (p.first_red == p.second_red && p.first_green == p.second_green &&
				p.first_blue == p.second_blue && p.first_alpha == p.second_alpha) begin
			r.difference   = '0;
			r.pixels_equal = 1'b1;
			return r;
		end
		dr = blend_q8(p.first_red, p.first_alpha) - blend_q8(p.second_red, p.second_alpha);
		dg = blend_q8(p.first_green, p.first_alpha) - blend_q8(p.second_green, p.second_alpha);
		db = blend_q8(p.first_blue, p.first_alpha) - blend_q8(p.second_blue, p.second_alpha);
		// i row subtracts green and blue, q row subtracts green
		dy = round_q(coef_q16(0) * dr + coef_q16(1) * dg + coef_q16(2) * db, COEF_FRAC);
		di = round_q(coef_q16(3) * dr - coef_q16(4) * dg - coef_q16(5) * db, COEF_FRAC);
		dq = round_q(coef_q16(6) * dr - coef_q16(7) * dg + coef_q16(8) * db, COEF_FRAC);
		if (m == MODE_LUMA) begin
			r.difference = ycd_pkg::diff_t'(dy);
		end else begin
			sum  = coef_q16(9) * (dy * dy) + coef_q16(10) * (di * di) +
				coef_q16(11) * (dq * dq);
			distance = round_q(sum, Q8_SHIFT + COEF_FRAC);
			if (distance > DISTANCE_CLIP)
				distance = DISTANCE_CLIP;
			r.difference = ycd_pkg::diff_t'(distance);
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// result side: random stall bursts and the check against the queue
	// ------------------------------------------------------------------------
	task automatic report_mismatch(string what, longint got, longint want, pixel_pair_t p);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch on %s at %0t: got %0d, want %0d, pair %h",
				what, $realtime, got, want, p);
	endtask

	always @(posedge clk) begin : result_check
		colour_delta_t want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			sink_stall = 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				results_checked++;
				if (pending_deltas.size() == 0) begin
					report_mismatch("unrequested result", res_if.difference, 0, '0);
				end else begin
					want = pending_deltas.pop_front();
					if (res_if.difference !== want.difference)
						report_mismatch("difference", res_if.difference,
							want.difference, want.pair);
					if (res_if.pixels_equal !== want.pixels_equal)
						report_mismatch("pixels_equal", longint'(res_if.pixels_equal),
							longint'(want.pixels_equal), want.pair);
				end
			end
			// random stall bursts while idling is enabled
			if (sink_stall > 0) begin
				sink_stall--;
				res_if.ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 9) == 0) begin
				sink_stall = $urandom_range(1, 19) - 1;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------
	// valid is left high on return so that back-to-back requests need no gap
	task automatic send_pair(input pixel_pair_t p);
		int gap;
		if (idle_en && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 19);
			pix_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_if.valid        <= 1'b1;
		pix_if.first_red    <= p.first_red;
		pix_if.first_green  <= p.first_green;
		pix_if.first_blue   <= p.first_blue;
		pix_if.first_alpha  <= p.first_alpha;
		pix_if.second_red   <= p.second_red;
		pix_if.second_green <= p.second_green;
		pix_if.second_blue  <= p.second_blue;
		pix_if.second_alpha <= p.second_alpha;
		do @(posedge clk); while (!pix_if.ready);
		// request taken on this edge, under the mode in force now
		pending_deltas.push_back(predict_colour_delta(p, luma_mode));
		pairs_sent++;
		if (pending_deltas[$].pixels_equal)
			equal_pairs++;
	endtask

	// stop requesting and wait until every queued result has come back
	task automatic drain_results();
		pix_if.valid <= 1'b0;
		do @(posedge clk); while (pending_deltas.size() != 0);
	endtask

	// mode changes only with the pipeline empty
	task automatic write_mode(input mode_t m);
		drain_results();
		cfg_if.valid     <= 1'b1;
		cfg_if.luma_only <= m;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		luma_mode = m;
		mode_writes++;
	endtask

	function automatic pixel_pair_t make_pair(int fr, int fg, int fb, int fa,
			int sr, int sg, int sb, int sa);
		return {ycd_pkg::chan_t'(fr), ycd_pkg::chan_t'(fg), ycd_pkg::chan_t'(fb),
			ycd_pkg::chan_t'(fa), ycd_pkg::chan_t'(sr), ycd_pkg::chan_t'(sg),
			ycd_pkg::chan_t'(sb), ycd_pkg::chan_t'(sa)};
	endfunction

	// opaque most of the time, with the blend corners mixed in
	function automatic ycd_pkg::chan_t pick_alpha();
		case ($urandom_range(0, 5))
			0, 1, 2: return 8'd255;
			3:       return 8'd0;
			4:       return 8'd254;
			default: return ycd_pkg::chan_t'($urandom);
		endcase
	endfunction

	function automatic pixel_pair_t random_pair();
		pixel_pair_t p;
		int          kind;
		p    = {$urandom, $urandom};
		kind = $urandom_range(0, 9);
		if (kind <= 5) begin
			p.first_alpha  = pick_alpha();
			p.second_alpha = pick_alpha();
		end
		if (kind >= 6 && kind <= 8) begin
			// second pixel a copy of the first, then maybe one channel moved
			p.second_red   = p.first_red;
			p.second_green = p.first_green;
			p.second_blue  = p.first_blue;
			p.second_alpha = p.first_alpha;
			if (kind != 6) begin
				case ($urandom_range(0, 3))
					0:       p.second_red   = ycd_pkg::chan_t'($urandom);
					1:       p.second_green = ycd_pkg::chan_t'($urandom);
					2:       p.second_blue  = ycd_pkg::chan_t'($urandom);
					default: p.second_alpha = ycd_pkg::chan_t'($urandom);
				endcase
			end
		end
		return p;
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	// distance mode straight out of reset, no write beforehand
	task automatic test_directed_distance();
		idle_en = 1'b0;
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));               // identical, all zero
		send_pair(make_pair(255, 255, 255, 255, 255, 255, 255, 255)); // identical, all ones
		send_pair(make_pair(0, 0, 0, 255, 255, 255, 255, 255));     // black against white
		send_pair(make_pair(255, 255, 255, 255, 0, 0, 0, 255));     // white against black
		send_pair(make_pair(255, 0, 0, 255, 0, 0, 0, 255));         // red only
		send_pair(make_pair(0, 255, 0, 255, 0, 0, 0, 255));         // green only
		send_pair(make_pair(10, 11, 12, 255, 10, 12, 12, 255));     // green off by one
		send_pair(make_pair(0, 0, 255, 255, 0, 0, 0, 255));         // blue only
		send_pair(make_pair(50, 100, 150, 255, 50, 100, 150, 128)); // alpha only
		send_pair(make_pair(0, 0, 0, 0, 255, 255, 255, 0));         // both clear, not equal
		send_pair(make_pair(200, 30, 90, 254, 200, 30, 90, 255));   // just short of opaque
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 255));             // clear against black
		send_pair(make_pair(255, 0, 255, 1, 0, 255, 0, 255));       // far corners
	endtask

	task automatic test_directed_luma();
		write_mode(MODE_LUMA);
		send_pair(make_pair(0, 0, 0, 255, 255, 255, 255, 255));     // most negative luma
		send_pair(make_pair(255, 255, 255, 255, 0, 0, 0, 255));     // most positive luma
		send_pair(make_pair(0, 255, 0, 255, 0, 0, 0, 255));         // green only
		send_pair(make_pair(123, 45, 67, 89, 123, 45, 67, 89));     // identical, translucent
		send_pair(make_pair(0, 0, 0, 0, 255, 255, 255, 0));         // both clear
		send_pair(make_pair(1, 2, 3, 255, 0, 0, 0, 255));           // tiny step
	endtask

	task automatic test_random_distance(input int count);
		write_mode(MODE_DISTANCE);
		idle_en = 1'b1;
		repeat (count) send_pair(random_pair());
	endtask

	// halfway through the sender holds off until the pipeline has emptied
	task automatic test_random_luma_with_pause(input int count);
		write_mode(MODE_LUMA);
		idle_en = 1'b1;
		repeat (count / 2) send_pair(random_pair());
		drain_results();
		repeat (count - count / 2) send_pair(random_pair());
	endtask

	task automatic test_random_mode_sweep(input int chunks, input int per_chunk);
		idle_en = 1'b1;
		for (int i = 0; i < chunks; i++) begin
			write_mode((i % 2) ? MODE_LUMA : MODE_DISTANCE);
			repeat (per_chunk) send_pair(random_pair());
		end
	endtask

	// closing stretch at full rate on both sides
	task automatic test_random_no_idle(input int count);
		idle_en = 1'b0;
		write_mode(MODE_DISTANCE);
		repeat (count) send_pair(random_pair());
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n              <= 1'b0;
		pix_if.valid        <= 1'b0;
		pix_if.first_red    <= '0;
		pix_if.first_green  <= '0;
		pix_if.first_blue   <= '0;
		pix_if.first_alpha  <= '0;
		pix_if.second_red   <= '0;
		pix_if.second_green <= '0;
		pix_if.second_blue  <= '0;
		pix_if.second_alpha <= '0;
		cfg_if.valid        <= 1'b0;
		cfg_if.luma_only    <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_distance();
		test_directed_luma();
		test_random_distance(400);
		test_random_luma_with_pause(400);
		test_random_mode_sweep(6, 60);
		test_random_no_idle(200);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d pixel pairs sent (%0d identical), %0d results checked, %0d mode writes",
			pairs_sent, equal_pairs, results_checked, mode_writes);
		$display("both modes, alpha blending, idle bursts on either side and a full drain");
		if (mismatch_count == 0 && pending_deltas.size() == 0) begin
			$display("** yiq_color_delta: PASSED **");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatch_count,
				pending_deltas.size());
			$display("** yiq_color_delta: FAILED **");
		end
		$finish;
	end

endmodule
